[hdl/mpid_pkg.sv]
// Shared constants and helpers for the multichannel PID controller.
// No dependencies; used by multichannel_pid_controller.
package mpid_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned ValW     = 16;
  localparam int unsigned KdW      = 8;
  // err * gain + integrator fits comfortably in 34 signed bits
  localparam int unsigned SumW     = 34;

  localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_GAIN = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DERIV_GAIN = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MIN_LIMIT  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LIMIT  = 3'd4;

  localparam logic MODE_COMPUTE = 1'b0;
  localparam logic MODE_CLEAR   = 1'b1;

  // raise to lo first, then lower to hi; result always lies in 16 bits
  function automatic logic signed [ValW-1:0] clamp_lim(
    input logic signed [SumW-1:0] v,
    input logic signed [ValW-1:0] lo,
    input logic signed [ValW-1:0] hi
  );
    logic signed [SumW-1:0] r;
    r = v;
    if (r < SumW'(lo)) r = SumW'(lo);
    if (r > SumW'(hi)) r = SumW'(hi);
    return r[ValW-1:0];
  endfunction

  // 16-bit slice of a packed three-channel table; channel 3 reads as zero
  function automatic logic signed [ValW-1:0] slice16(
    input logic [CfgDataW-1:0] tbl,
    input logic [1:0]          ch
  );
    logic signed [ValW-1:0] s;
    case (ch)
      2'd0:    s = tbl[15:0];
      2'd1:    s = tbl[31:16];
      2'd2:    s = tbl[47:32];
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

[hdl/multichannel_pid_controller.sv]
// Multichannel PID controller, derivative taken on the measurement.
// Depends on mpid_pkg (constants, clamp and table slice helpers).
//
// Usage: configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i
// while the block is idle (gains, packed per channel, channel 0 low).
// Input beats on in_valid_i/in_ready_o carry mode, channel, setpoint and
// measurement. A compute beat on a channel below CHANNELS gives one output
// beat (out_channel_o, drive_value_o) on out_valid_o/out_ready_i; a clear beat
// gives none and only touches state; a beat on a missing channel gives none.
// A beat is registered at the input, then the products, integrator update
// and clamps are worked out in one pass into the output register.
// Throughput is one beat per cycle while the output does not stall, set
// by the read-modify-write of the channel state (integrator, previous
// measurement, first-sample flag) as a beat leaves the input register,
// so back-to-back beats on one channel see fresh state.
// If the receiver stalls, the output register holds its beat and the input
// register takes one more; in_ready_o then drops until the output drains.
// Reset clears all tables to zero, integrators and previous samples to
// zero, and sets every channel's first-sample flag.
module multichannel_pid_controller #(
  parameter int unsigned CHANNELS = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mpid_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mpid_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [1:0]                        channel_i,
  input  logic signed [mpid_pkg::ValW-1:0]  setpoint_value_i,
  input  logic signed [mpid_pkg::ValW-1:0]  measured_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        out_channel_o,
  output logic signed [mpid_pkg::ValW-1:0]  drive_value_o
);

  localparam int unsigned ValW = mpid_pkg::ValW;
  localparam int unsigned SumW = mpid_pkg::SumW;
  localparam int unsigned KdW  = mpid_pkg::KdW;

  // configuration tables
  logic [mpid_pkg::CfgDataW-1:0] kp_tbl_q, ki_tbl_q, lo_tbl_q, hi_tbl_q;
  logic [3*KdW-1:0]              kd_tbl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_tbl_q <= '0;
      ki_tbl_q <= '0;
      kd_tbl_q <= '0;
      lo_tbl_q <= '0;
      hi_tbl_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mpid_pkg::CFG_PROP_GAIN:  kp_tbl_q <= cfg_data_i;
        mpid_pkg::CFG_INTEG_GAIN: ki_tbl_q <= cfg_data_i;
        mpid_pkg::CFG_DERIV_GAIN: kd_tbl_q <= cfg_data_i[3*KdW-1:0];
        mpid_pkg::CFG_MIN_LIMIT:  lo_tbl_q <= cfg_data_i;
        mpid_pkg::CFG_MAX_LIMIT:  hi_tbl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic                   s1_valid_q;
  logic                   s1_mode_q;
  logic [1:0]             s1_ch_q;
  logic signed [ValW-1:0] s1_sp_q, s1_meas_q;

  // output register
  logic                   out_valid_q;
  logic [1:0]             out_ch_q;
  logic signed [ValW-1:0] out_drive_q;

  // per-channel loop state
  logic signed [ValW-1:0] integ_q [CHANNELS];
  logic signed [ValW-1:0] prev_q  [CHANNELS];
  logic [CHANNELS-1:0]    first_q;

  logic s1_in_range, s1_emit, s1_adv, out_free, in_acc;

  assign s1_in_range = (int'(s1_ch_q) < CHANNELS);
  assign s1_emit     = s1_in_range && (s1_mode_q == mpid_pkg::MODE_COMPUTE);
  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_adv      = s1_valid_q && (!s1_emit || out_free);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_acc      = in_valid_i && in_ready_o;

  // select the addressed channel's state
  logic signed [ValW-1:0] cur_integ, cur_prev;
  logic                   cur_first;
  logic [CHANNELS-1:0]    ch_hit;

  always_comb begin
    cur_integ = '0;
    cur_prev  = '0;
    cur_first = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      ch_hit[c] = (s1_ch_q == 2'(c));
      if (ch_hit[c]) begin
        cur_integ = integ_q[c];
        cur_prev  = prev_q[c];
        cur_first = first_q[c];
      end
    end
  end

  // datapath
  logic signed [ValW-1:0] kp, ki, lo, hi, prev_eff, integ_d, drive_d;
  logic [KdW-1:0]         kd;
  logic signed [ValW:0]   err, dmeas;
  logic signed [KdW:0]    kd_s;
  logic signed [SumW-1:0] p_term, i_sum, d_term, res_sum;

  always_comb begin
    kp = mpid_pkg::slice16(kp_tbl_q, s1_ch_q);
    ki = mpid_pkg::slice16(ki_tbl_q, s1_ch_q);
    lo = mpid_pkg::slice16(lo_tbl_q, s1_ch_q);
    hi = mpid_pkg::slice16(hi_tbl_q, s1_ch_q);
    case (s1_ch_q)
      2'd0:    kd = kd_tbl_q[KdW-1:0];
      2'd1:    kd = kd_tbl_q[2*KdW-1:KdW];
      2'd2:    kd = kd_tbl_q[3*KdW-1:2*KdW];
      default: kd = '0;
    endcase
    kd_s = signed'({1'b0, kd});

    err      = (ValW+1)'(s1_sp_q) - (ValW+1)'(s1_meas_q);
    p_term   = SumW'(err) * SumW'(kp);
    i_sum    = SumW'(cur_integ) + SumW'(err) * SumW'(ki);
    integ_d  = mpid_pkg::clamp_lim(i_sum, lo, hi);

    // first sample after a clear: no derivative kick
    prev_eff = cur_first ? s1_meas_q : cur_prev;
    dmeas    = (ValW+1)'(s1_meas_q) - (ValW+1)'(prev_eff);
    d_term   = SumW'(dmeas) * SumW'(kd_s);

    res_sum  = p_term + SumW'(integ_d) - d_term;
    drive_d  = mpid_pkg::clamp_lim(res_sum, lo, hi);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q <= mode_i;
      s1_ch_q   <= channel_i;
      s1_sp_q   <= setpoint_value_i;
      s1_meas_q <= measured_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        integ_q[c] <= '0;
        prev_q[c]  <= '0;
      end
      first_q <= '1;
    end else if (s1_adv && s1_in_range) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (ch_hit[c]) begin
          if (s1_mode_q == mpid_pkg::MODE_CLEAR) begin
            integ_q[c] <= '0;
            prev_q[c]  <= '0;
            first_q[c] <= 1'b1;
          end else begin
            integ_q[c] <= integ_d;
            prev_q[c]  <= s1_meas_q;
            first_q[c] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit) begin
      out_ch_q    <= s1_ch_q;
      out_drive_q <= drive_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign drive_value_o = out_drive_q;

endmodule
